// File: rtl/blss_pkg.sv
// shared types and constants for the bounded stack with search
`timescale 1ns / 1ps
`default_nettype none

package blss_pkg;

  // entry store geometry
  localparam int STK_DEPTH  = 64;
  localparam int STK_CNT_W  = $clog2(STK_DEPTH + 1);
  localparam int STK_IDX_W  = $clog2(STK_DEPTH);
  localparam int STK_WORD_W = 32;

  // search priority tree: groups of cells resolved in two registered levels
  localparam int GRP_SIZE = 8;
  localparam int GRP_N    = STK_DEPTH / GRP_SIZE;
  localparam int GRP_W    = $clog2(GRP_SIZE);

  // configuration port
  localparam int ADDR_W = 1;
  localparam logic [ADDR_W-1:0] REG_CAPACITY = 1'b0;
  localparam int CAP_W  = 7;

  // request field widths
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;
  localparam int FOUND_W  = 6;

  // operation codes
  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH   = 3'd0,
    KIND_POP    = 3'd1,
    KIND_PEEK   = 3'd2,
    KIND_CLEAR  = 3'd3,
    KIND_SEARCH = 3'd4
  } kind_t;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  // per-cycle commands broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
    logic cmp;
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: rtl/blss_cell.sv
// one stack cell: holds a word, shifts with its neighbors, compares against the search key
`timescale 1ns / 1ps
`default_nettype none

module blss_cell (
  input  wire logic                             clk,
  input  wire blss_pkg::cell_ctl_t              ctl,
  input  wire logic [blss_pkg::STK_WORD_W-1:0]  from_up,
  input  wire logic [blss_pkg::STK_WORD_W-1:0]  from_down,
  input  wire logic [blss_pkg::STK_WORD_W-1:0]  key,
  input  wire logic                             held,
  output logic      [blss_pkg::STK_WORD_W-1:0]  word,
  output logic                                  match
);

  // push moves words away from the top, pop moves them toward it
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      word <= from_up;
    end else if (ctl.pop) begin
      word <= from_down;
    end
  end

  // match only counts for cells that hold a live entry
  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      match <= held && (word == key);
    end
  end

endmodule

`default_nettype wire

// File: rtl/bounded_lifo_stack_with_search.sv
// top level: bounded lifo stack with search, built as a chain of shifting cells
//
//  channel   dir  handshake         payload
//  s_axis    in   tvalid / tready   tdata = value, tuser = kind
//  m_axis    out  tvalid / tready   tdata = data, found_index, count, flags; tuser = status
//  apb       in   psel / penable    capacity_limit at address 0
//
// push, pop, peek, clear and unknown kinds: result register, then output register
// search: compare in every cell, group priority level, final priority level, then done
// one request is in flight at a time; the next is accepted once the result is in the output register,
// even while that result still waits on m_tready
// synchronous reset empties the stack and sets the capacity to 64; no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none

module bounded_lifo_stack_with_search (
  input  wire logic        clk,
  input  wire logic        rst,
  // request stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] value
  input  wire logic [2:0]  s_tuser,   // [2:0] kind
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [47:0] m_tdata,   // [31:0] data, [37:32] found_index, [44:38] count,
                                      // [45] is_empty, [46] is_full, [47] zero
  output logic      [1:0]  m_tuser,   // [1:0] status
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [0:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int DEPTH = blss_pkg::STK_DEPTH;
  localparam int CW    = blss_pkg::STK_CNT_W;
  localparam int WW    = blss_pkg::STK_WORD_W;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_MATCH   = 5'b00010,
    ST_GROUP   = 5'b00100,
    ST_RESOLVE = 5'b01000,
    ST_DONE    = 5'b10000
  } state_t;

  typedef struct packed {
    logic [blss_pkg::STATUS_W-1:0] status;
    logic [WW-1:0]                 data;
    logic [blss_pkg::FOUND_W-1:0]  found;
    logic [CW-1:0]                 count;
    logic                          empty;
    logic                          full;
  } res_t;

  state_t                         state, state_next;
  logic [CW-1:0]                  count, count_next;
  logic [blss_pkg::CAP_W-1:0]     capacity;
  logic [CW-1:0]                  eff_cap;
  logic [WW-1:0]                  key;
  res_t                           res, res_next;
  blss_pkg::cell_ctl_t            ctl;
  logic                           accept;
  logic                           out_free;

  logic [WW-1:0]                  cell_word [DEPTH];
  logic [DEPTH-1:0]               cell_match;
  logic [DEPTH-1:0]               cell_held;

  logic [blss_pkg::GRP_N-1:0]     grp_any, grp_any_c;
  logic [blss_pkg::GRP_W-1:0]     grp_idx   [blss_pkg::GRP_N];
  logic [blss_pkg::GRP_W-1:0]     grp_idx_c [blss_pkg::GRP_N];
  logic [blss_pkg::STK_IDX_W-1:0] hit_pos;
  logic [CW-1:0]                  hit_from_bottom;

  assign pready   = 1'b1;
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // effective capacity is the smaller of the register and the depth
  assign eff_cap = (CW'(capacity) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(capacity);

  // configuration register write and read
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= blss_pkg::CAP_W'(64);
    end else if (psel && penable && pwrite && (paddr == blss_pkg::REG_CAPACITY)) begin
      capacity <= pwdata[blss_pkg::CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == blss_pkg::REG_CAPACITY) begin
      prdata = 32'(capacity);
    end
  end

  // cell commands
  always_comb begin
    ctl.push = accept && (s_tuser == blss_pkg::KIND_PUSH) && (count < eff_cap);
    ctl.pop  = accept && (s_tuser == blss_pkg::KIND_POP) && (count != '0);
    ctl.cmp  = (state == ST_MATCH);
  end

  // the chain: cell 0 is the top of the stack
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [WW-1:0] up_word;
    logic [WW-1:0] down_word;

    if (k == 0) begin : g_top
      assign up_word = s_tdata;
    end else begin : g_mid
      assign up_word = cell_word[k-1];
    end

    if (k == DEPTH - 1) begin : g_bot
      assign down_word = cell_word[k];
    end else begin : g_nbot
      assign down_word = cell_word[k+1];
    end

    assign cell_held[k] = count > CW'(k);

    blss_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .from_up   (up_word),
      .from_down (down_word),
      .key       (key),
      .held      (cell_held[k]),
      .word      (cell_word[k]),
      .match     (cell_match[k])
    );
  end

  // first priority level: nearest-top match within each group of cells
  always_comb begin
    for (int g = 0; g < blss_pkg::GRP_N; g++) begin
      grp_any_c[g] = |cell_match[g*blss_pkg::GRP_SIZE +: blss_pkg::GRP_SIZE];
      grp_idx_c[g] = '0;
      for (int j = blss_pkg::GRP_SIZE - 1; j >= 0; j--) begin
        if (cell_match[g*blss_pkg::GRP_SIZE + j]) begin
          grp_idx_c[g] = blss_pkg::GRP_W'(j);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_GROUP) begin
      grp_any <= grp_any_c;
      grp_idx <= grp_idx_c;
    end
  end

  // second priority level: first group with a hit, turned into a position from the bottom
  always_comb begin
    hit_pos = '0;
    for (int g = blss_pkg::GRP_N - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        hit_pos = blss_pkg::STK_IDX_W'(g * blss_pkg::GRP_SIZE) +
                  blss_pkg::STK_IDX_W'(grp_idx[g]);
      end
    end
    hit_from_bottom = count - CW'(1) - CW'(hit_pos);
  end

  // sequencer and result build
  always_comb begin
    state_next = state;
    count_next = count;
    res_next   = res;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          res_next.status = blss_pkg::ST_OK;
          res_next.data   = '0;
          res_next.found  = '0;
          state_next      = ST_DONE;
          case (s_tuser)
            blss_pkg::KIND_PUSH: begin
              if (count >= eff_cap) begin
                res_next.status = blss_pkg::ST_FULL;
              end else begin
                count_next = count + CW'(1);
              end
            end
            blss_pkg::KIND_POP: begin
              if (count == '0) begin
                res_next.status = blss_pkg::ST_EMPTY;
              end else begin
                count_next    = count - CW'(1);
                res_next.data = cell_word[0];
              end
            end
            blss_pkg::KIND_PEEK: begin
              if (count == '0) begin
                res_next.status = blss_pkg::ST_EMPTY;
              end else begin
                res_next.data = cell_word[0];
              end
            end
            blss_pkg::KIND_CLEAR: begin
              count_next = '0;
            end
            blss_pkg::KIND_SEARCH: begin
              state_next = ST_MATCH;
            end
            default: begin
            end
          endcase
          res_next.count = count_next;
          res_next.empty = (count_next == '0);
          res_next.full  = (count_next >= eff_cap);
        end
      end
      ST_MATCH: begin
        state_next = ST_GROUP;
      end
      ST_GROUP: begin
        state_next = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        if (|grp_any) begin
          res_next.found = hit_from_bottom[blss_pkg::FOUND_W-1:0];
        end else begin
          res_next.status = blss_pkg::ST_NOTFOUND;
        end
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // result and key payload
  always_ff @(posedge clk) begin
    res <= res_next;
    if (accept) begin
      key <= s_tdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_tdata <= {1'b0, res.full, res.empty, res.count, res.found, res.data};
      m_tuser <= res.status;
    end
  end

`ifndef SYNTHESIS
  // fill count never passes the depth of the chain
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fill count beyond depth");

  // one request at a time: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("request accepted while another is in flight");

  // a finished result reaches the output register
  a_done_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) && out_free |=> m_tvalid)
    else $error("result not registered");

  // the empty flag agrees with the count it travels with
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[45] == (m_tdata[44:38] == '0)))
    else $error("empty flag disagrees with count");
`endif

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// self-checking testbench for the bounded lifo stack with search
`timescale 1ns / 1ps

module tb_top;
  import blss_pkg::*;

  // result fields as the stack reports them
  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [31:0]           data;
    logic [FOUND_W-1:0]    found_index;
    logic [STK_CNT_W-1:0]  count;
    logic                  is_empty;
    logic                  is_full;
  } stack_result_t;

  // one stack operation waiting to be sent
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [31:0]       value;
  } stack_op_t;

  localparam logic [KIND_W-1:0] KIND_FIRST_UNUSED = KIND_SEARCH + 3'd1;
  localparam logic [KIND_W-1:0] KIND_TOP          = '1;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [31:0]         s_tdata = '0;
  logic [KIND_W-1:0]   s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [47:0]         m_tdata;
  logic [STATUS_W-1:0] m_tuser;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  // mirror of the stack contents and settings
  logic [31:0]   stk_word [STK_DEPTH];
  int            stk_fill = 0;
  int            stk_cap = STK_DEPTH;

  stack_op_t     pending_ops [$];
  stack_result_t expected_results [$];
  logic [31:0]   word_pool [8];
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            err_count = 0;
  int            stall_cycles = 0;

  bounded_lifo_stack_with_search dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [31:0] value
    .s_tuser  (s_tuser),   // [2:0] kind
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // [31:0] data, [37:32] found_index, [44:38] count,
                           // [45] is_empty, [46] is_full, [47] zero
    .m_tuser  (m_tuser),   // [1:0] status
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #1 clk = ~clk;

  // apply one operation to the mirror and return what the stack should report
  function automatic stack_result_t stack_apply(logic [KIND_W-1:0] kind, logic [31:0] value);
    stack_result_t r;
    int eff_cap;
    bit hit;
    r = '0;
    r.status = ST_OK;
    hit = 1'b0;
    eff_cap = (stk_cap > STK_DEPTH) ? STK_DEPTH : stk_cap;
    case (kind)
      KIND_PUSH: begin
        if (stk_fill >= eff_cap) begin
          r.status = ST_FULL;
        end else begin
          stk_word[stk_fill] = value;
          stk_fill++;
        end
      end
      KIND_POP: begin
        if (stk_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          stk_fill--;
          r.data = stk_word[stk_fill];
        end
      end
      KIND_PEEK: begin
        if (stk_fill == 0) r.status = ST_EMPTY;
        else r.data = stk_word[stk_fill-1];
      end
      KIND_CLEAR: begin
        stk_fill = 0;
      end
      KIND_SEARCH: begin
        // topmost match wins
        for (int i = stk_fill - 1; i >= 0 && !hit; i--) begin
          if (stk_word[i] == value) begin
            hit = 1'b1;
            r.found_index = FOUND_W'(i);
          end
        end
        if (!hit) r.status = ST_NOTFOUND;
      end
      default: ;
    endcase
    r.count    = STK_CNT_W'(stk_fill);
    r.is_empty = (stk_fill == 0);
    r.is_full  = (stk_fill >= eff_cap);
    return r;
  endfunction

  task automatic add_op(input logic [KIND_W-1:0] kind, input logic [31:0] value);
    stack_op_t op;
    op.kind = kind;
    op.value = value;
    pending_ops.push_back(op);
  endtask

  // mostly words from a small pool so that searches hit and duplicates occur
  function automatic logic [31:0] pick_word();
    if ($urandom_range(9) < 6) return word_pool[$urandom_range(7)];
    return $urandom();
  endfunction

  task automatic add_random_ops(input int n, input int push_pct, input int pop_pct);
    int roll;
    int sub;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      sub = $urandom_range(19);
      if (roll < push_pct) add_op(KIND_PUSH, pick_word());
      else if (roll < push_pct + pop_pct) add_op(KIND_POP, $urandom());
      else if (sub == 0) add_op(KIND_CLEAR, $urandom());
      else if (sub == 1) add_op(KIND_W'($urandom_range(KIND_TOP, KIND_FIRST_UNUSED)), $urandom());
      else if (sub < 9) add_op(KIND_PEEK, $urandom());
      else add_op(KIND_SEARCH, pick_word());
    end
  endtask

  // setup then access phase; register takes the value at the access edge
  task automatic write_capacity(input logic [31:0] wdata);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= REG_CAPACITY;
    pwdata <= wdata;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    stk_cap = int'(wdata[CAP_W-1:0]);
  endtask

  // wait until every request is sent and every result has come back
  task automatic wait_drained();
    while (pending_ops.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v, input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      err_count++;
    end
  endtask

  // request driver: predicts each accepted request, then offers the next one
  always @(posedge clk) begin
    logic took;
    stack_op_t op;
    took = s_tvalid && s_tready;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (took) expected_results.push_back(stack_apply(s_tuser, s_tdata));
      if (!s_tvalid || took) begin
        if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          op = pending_ops.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= op.kind;
          s_tdata <= op.value;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk) begin
    stack_result_t exp_r;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected, actual status %0h data %0h",
                   $time, m_tuser, m_tdata);
          err_count++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("status", 32'(exp_r.status), 32'(m_tuser));
          check_field("data", exp_r.data, m_tdata[31:0]);
          check_field("found_index", 32'(exp_r.found_index), 32'(m_tdata[37:32]));
          check_field("count", 32'(exp_r.count), 32'(m_tdata[44:38]));
          check_field("is_empty", 32'(exp_r.is_empty), 32'(m_tdata[45]));
          check_field("is_full", 32'(exp_r.is_full), 32'(m_tdata[46]));
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    word_pool[0] = 32'h8000_0000;
    word_pool[1] = 32'h7fff_ffff;
    word_pool[2] = '0;
    word_pool[3] = '1;
    for (int i = 4; i < 8; i++) word_pool[i] = $urandom();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // sender idles lightly, receiver heavily
    send_idle_pct = 17;
    recv_idle_pct = 47;

    // directed: empty stack errors, extreme words, duplicates, unknown kinds, clear
    add_op(KIND_POP, 32'h0);
    add_op(KIND_PEEK, 32'hffff_ffff);
    add_op(KIND_SEARCH, 32'h0);
    add_op(KIND_PUSH, 32'h8000_0000);
    add_op(KIND_PUSH, 32'h7fff_ffff);
    add_op(KIND_PUSH, 32'h0);
    add_op(KIND_PUSH, 32'hffff_ffff);
    add_op(KIND_PUSH, 32'h8000_0000);
    add_op(KIND_PEEK, 32'h0);
    add_op(KIND_SEARCH, 32'h8000_0000);
    add_op(KIND_SEARCH, 32'h7fff_ffff);
    add_op(KIND_SEARCH, 32'h1234_5678);
    for (int k = KIND_FIRST_UNUSED; k <= KIND_TOP; k++) add_op(KIND_W'(k), $urandom());
    add_op(KIND_POP, 32'h0);
    add_op(KIND_SEARCH, 32'h8000_0000);
    add_op(KIND_POP, 32'h0);
    add_op(KIND_CLEAR, 32'hffff_ffff);
    add_op(KIND_POP, 32'h0);
    add_op(KIND_SEARCH, 32'h0);
    wait_drained();

    // full depth, filling up to the capacity
    write_capacity(32'd64);
    add_random_ops(150, 60, 25);
    wait_drained();

    // capacity lowered below the held count
    write_capacity(32'd10);
    add_random_ops(60, 30, 35);
    wait_drained();

    // receiver idles lightly, sender heavily
    send_idle_pct = 47;
    recv_idle_pct = 17;

    // capacity above the depth
    write_capacity(32'd127);
    add_random_ops(150, 55, 30);
    wait_drained();

    // zero capacity refuses every push
    write_capacity(32'd0);
    add_random_ops(40, 40, 25);
    wait_drained();

    write_capacity(32'd1);
    add_random_ops(40, 45, 30);
    wait_drained();

    // no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_capacity(32'($urandom_range(63, 2)));
    add_random_ops(150, 50, 30);
    wait_drained();

    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
